// ----- sv/fsl_pkg.sv -----
// ----------------------------------------------------------------------------
// fsl_pkg: shared types and constants for the force sensor linearizer
// Calibration table, field widths and sequencer state encoding.
// ----------------------------------------------------------------------------
package fsl_pkg;

  localparam int CODE_W   = 16;
  localparam int SUPPLY_W = 13;
  localparam int SERIES_W = 20;
  localparam int GRAMS_W  = 22;
  localparam int TOTAL_W  = 24;
  localparam int CFG_W    = 20;
  localparam int NPTS     = 12;

  // den = 3*code fits 18 bits, top = 32*supply fits 18 bits
  localparam int DEN_W = 18;
  // num = series*(top-den) fits 38 bits
  localparam int NUM_W = 38;
  // table products r*den: 100000*196605 < 2^35
  localparam int RD_W  = 38;
  // n<<8 up to 100000*d*256, d < 2^35 -> about 2^59
  localparam int N_W   = 62;
  localparam int D_W   = 38;
  localparam int Q_W   = 25;

  localparam logic [0:0] CFG_SUPPLY = 1'b0;
  localparam logic [0:0] CFG_SERIES = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEARCH,
    ST_NUM,
    ST_DIV,
    ST_GRAM,
    ST_NEXT,
    ST_DONE
  } fsl_state_t;

  function automatic logic [16:0] tab_res(input logic [3:0] i);
    case (i)
      4'd0:  tab_res = 17'd0;
      4'd1:  tab_res = 17'd250;
      4'd2:  tab_res = 17'd300;
      4'd3:  tab_res = 17'd450;
      4'd4:  tab_res = 17'd700;
      4'd5:  tab_res = 17'd1200;
      4'd6:  tab_res = 17'd2000;
      4'd7:  tab_res = 17'd3500;
      4'd8:  tab_res = 17'd6000;
      4'd9:  tab_res = 17'd10000;
      4'd10: tab_res = 17'd30000;
      4'd11: tab_res = 17'd100000;
      default: tab_res = 17'd0;
    endcase
  endfunction

  function automatic logic [16:0] tab_force(input logic [3:0] i);
    case (i)
      4'd0:  tab_force = 17'd100000;
      4'd1:  tab_force = 17'd10000;
      4'd2:  tab_force = 17'd7000;
      4'd3:  tab_force = 17'd4000;
      4'd4:  tab_force = 17'd2000;
      4'd5:  tab_force = 17'd1000;
      4'd6:  tab_force = 17'd500;
      4'd7:  tab_force = 17'd250;
      4'd8:  tab_force = 17'd100;
      4'd9:  tab_force = 17'd50;
      4'd10: tab_force = 17'd20;
      4'd11: tab_force = 17'd12;
      default: tab_force = 17'd12;
    endcase
  endfunction

endpackage

// ----- sv/fsl_if.sv -----
// ----------------------------------------------------------------------------
// fsl_if: valid/ready channel carrying a generic payload
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface fsl_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/fsl_mul.sv -----
// ----------------------------------------------------------------------------
// fsl_mul: bit-serial unsigned multiplier
// Shift-add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module fsl_mul #(
  parameter int AW = 38,
  parameter int BW = 24,
  parameter int PW = 62
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          done,
  output logic [PW-1:0] p
);
  localparam int CW = $clog2(BW + 1);
  logic [PW-1:0] acc;
  logic [PW-1:0] sa;
  logic [BW-1:0] sb;
  logic [CW-1:0] cnt;
  logic          busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(BW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      sa  <= PW'(a);
      sb  <= b;
    end else if (busy) begin
      if (sb[0]) acc <= acc + sa;
      sa <= sa << 1;
      sb <= sb >> 1;
    end
  end

  assign p = acc;
endmodule

// ----- sv/fsl_div.sv -----
// ----------------------------------------------------------------------------
// fsl_div: restoring divider, one quotient bit per cycle
// Quotient is NW bits wide; the caller truncates it to Q_W or GRAMS_W bits and guarantees it fits.
// ----------------------------------------------------------------------------
module fsl_div #(
  parameter int NW = 62,
  parameter int DW = 38
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic          done,
  output logic [NW-1:0] q
);
  localparam int CW = $clog2(NW + 1);
  logic [DW:0]   rem;
  logic [NW-1:0] sh;
  logic [DW-1:0] dv;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;

  assign trial = {rem[DW-1:0], sh[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      sh  <= n;
      dv  <= d;
    end else if (busy) begin
      if (trial >= {1'b0, dv}) begin
        rem <= trial - {1'b0, dv};
        sh  <= {sh[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        sh  <= {sh[NW-2:0], 1'b0};
      end
    end
  end

  assign q = sh;
endmodule

// ----- sv/force_sensor_linearizer.sv -----
// ----------------------------------------------------------------------------
// force_sensor_linearizer: resistive force sensor calibration, four channels
// Per channel: a zero code, or one past the last table point, saturates to the
// last table force; interpolating uses the multiplier three times and the
// divider twice, and every channel ends with the grams conversion.
// One item at a time, next accepted in the cycle after the result is taken.
// Reset (rst, synchronous) restores supply 5000 mV and series 10000 ohms.
// ----------------------------------------------------------------------------
module force_sensor_linearizer #(
  parameter int CHANNELS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [fsl_pkg::CFG_W-1:0]    cfg_data,
  fsl_if.sink                          in_ch,
  fsl_if.source                        out_ch
);
  import fsl_pkg::*;

  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // in_ch.data: code_ch0 in the low 16 bits, then ch1 ...
  // out_ch.data: {range_flags, grams_ch3..0, total_grams}

  logic [SUPPLY_W-1:0] supply_mv;
  logic [SERIES_W-1:0] series;

  always_ff @(posedge clk) begin
    if (rst) begin
      supply_mv <= SUPPLY_W'(5000);
      series    <= SERIES_W'(10000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SUPPLY: supply_mv <= cfg_data[SUPPLY_W-1:0];
        CFG_SERIES: series    <= cfg_data[SERIES_W-1:0];
        default: ;
      endcase
    end
  end

  fsl_state_t state, state_next;

  logic [CODE_W*CHANNELS-1:0] codes;
  logic [CHW-1:0]             ch;
  logic [CODE_W-1:0]          code;
  logic [DEN_W-1:0]           den;
  logic [NUM_W-1:0]           num;
  logic [3:0]                 idx;
  logic [1:0]                 phase;   // SEARCH and NUM sub-steps
  logic [D_W-1:0]             dd;
  logic [N_W-1:0]             acc_n;
  logic [GRAMS_W-1:0]         grams [CHANNELS];
  logic [CHANNELS-1:0]        flags;
  logic [TOTAL_W-1:0]         total;
  logic                       res_valid;

  assign code = codes[CODE_W-1:0];

  // shared serial multiplier and divider
  logic          m_start, m_done;
  logic [37:0]   m_a;
  logic [23:0]   m_b;
  logic [61:0]   m_p;
  logic          d_start, d_done;
  logic [N_W-1:0] d_n;
  logic [D_W-1:0] d_d;
  logic [N_W-1:0] d_q;

  fsl_mul #(.AW(38), .BW(24), .PW(62)) u_mul (
    .clk, .rst, .start(m_start), .a(m_a), .b(m_b), .done(m_done), .p(m_p)
  );
  fsl_div #(.NW(N_W), .DW(D_W)) u_div (
    .clk, .rst, .start(d_start), .n(d_n), .d(d_d), .done(d_done), .q(d_q)
  );

  // table compare: one point per cycle in SEARCH, once num is ready
  logic [RD_W-1:0] rd_cur;
  logic [16:0]     r1, r2, f1, f2;
  logic [17:0]     top;
  assign rd_cur = RD_W'(tab_res(idx)) * RD_W'(den);
  assign r1 = tab_res(idx - 4'd1);
  assign r2 = tab_res(idx);
  assign f1 = tab_force(idx - 4'd1);
  assign f2 = tab_force(idx);
  assign top = {supply_mv, 5'd0};

  logic gr_mode;   // divider currently doing the grams conversion
  logic sat;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_ch.valid && in_ch.ready) state_next = ST_PREP;
      ST_PREP:   state_next = (code == '0) ? ST_GRAM : ST_SEARCH;
      ST_SEARCH: begin
        if (!m_start && !m_done && phase == 2'd0) begin
          if (rd_cur > RD_W'(num)) state_next = ST_NUM;
          else if (idx == 4'(NPTS - 1)) state_next = ST_GRAM;
        end
      end
      ST_NUM:    if (phase == 2'd3 && m_done) state_next = ST_DIV;
      ST_DIV:    if (d_done) state_next = ST_GRAM;
      ST_GRAM:   if (d_done) state_next = ST_NEXT;
      ST_NEXT:   state_next = (ch == CHW'(CHANNELS - 1)) ? ST_DONE : ST_PREP;
      ST_DONE:   if (!res_valid || out_ch.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state == ST_IDLE) && !res_valid;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      m_start   <= 1'b0;
      d_start   <= 1'b0;
      phase     <= 2'd0;
      gr_mode   <= 1'b0;
    end else begin
      m_start <= 1'b0;
      d_start <= 1'b0;
      if (res_valid && out_ch.ready) res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            codes <= in_ch.data;
            ch    <= '0;
            flags <= '0;
            total <= '0;
          end
        end
        ST_PREP: begin
          den   <= DEN_W'(3 * code);
          idx   <= 4'd1;
          phase <= 2'd1;
          sat   <= (code == '0);
          gr_mode <= 1'b0;
          if (code == '0) begin
            d_n <= N_W'(({17'd0, tab_force(4'(NPTS - 1))} << 8) * 100 + 490);
            d_d <= D_W'(981);
            d_start <= 1'b1;
            gr_mode <= 1'b1;
          end else begin
            // num = series*(top-den): start multiply
            m_a <= 38'(series);
            m_b <= (top > 18'(3 * code)) ? 24'(top - 18'(3 * code)) : 24'd0;
            m_start <= 1'b1;
          end
        end
        ST_SEARCH: begin
          if (phase == 2'd1) begin
            if (m_done) begin
              num   <= NUM_W'(m_p);
              phase <= 2'd0;
            end
          end else if (rd_cur > RD_W'(num)) begin
            // d = (r2-r1)*den; diff = num - r1*den
            dd    <= D_W'((RD_W'(r2 - r1)) * RD_W'(den));
            m_a   <= 38'(num - NUM_W'(RD_W'(r1) * RD_W'(den)));
            m_b   <= 24'((f1 >= f2) ? (f1 - f2) : (f2 - f1));
            m_start <= 1'b1;
            phase <= 2'd2;
          end else if (idx == 4'(NPTS - 1)) begin
            sat <= 1'b1;
            d_n <= N_W'(({17'd0, tab_force(4'(NPTS - 1))} << 8) * 100 + 490);
            d_d <= D_W'(981);
            d_start <= 1'b1;
            gr_mode <= 1'b1;
          end else begin
            idx <= idx + 4'd1;
          end
        end
        ST_NUM: begin
          if (phase == 2'd2 && m_done) begin
            acc_n <= m_p;  // slope term
            m_a   <= dd;
            m_b   <= 24'(f1);
            m_start <= 1'b1;
            phase <= 2'd3;
          end else if (phase == 2'd3 && m_done) begin
            d_n <= ((f1 >= f2) ? (m_p - acc_n) : (m_p + acc_n)) << 8;
            d_d <= dd;
            d_start <= 1'b1;
          end
        end
        ST_DIV: begin
          if (d_done) begin
            d_n <= N_W'(d_q[Q_W-1:0]) * N_W'(100) + N_W'(490);
            d_d <= D_W'(981);
            d_start <= 1'b1;
            gr_mode <= 1'b1;
          end
        end
        ST_GRAM: begin
          if (d_done) begin
            grams[ch] <= d_q[GRAMS_W-1:0];
            total     <= total + TOTAL_W'(d_q[GRAMS_W-1:0]);
            flags[ch] <= sat;
          end
        end
        ST_NEXT: begin
          ch    <= ch + 1'b1;
          codes <= codes >> CODE_W;
        end
        ST_DONE: begin
          if (!res_valid || out_ch.ready) res_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_ch.data = '0;
    out_ch.data[TOTAL_W-1:0] = total;
    for (int c = 0; c < CHANNELS; c++) begin
      out_ch.data[TOTAL_W + c*GRAMS_W +: GRAMS_W] = grams[c];
    end
    out_ch.data[TOTAL_W + CHANNELS*GRAMS_W +: CHANNELS] = flags;
  end
  assign out_ch.valid = res_valid;

  // grams conversion only runs in the last phase of a channel
  a_gram: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GRAM && d_done) |-> gr_mode) else $error("grams without conv");
  a_noin: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == ST_IDLE) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_ch.ready) |=> res_valid) else $error("result dropped");
endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for force_sensor_linearizer
// Sends items of four converter codes, predicts each channel weight, the
// total and the range flags, and compares them with the results. Runs a
// directed table and then random items under several supply and series
// resistor settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
  import fsl_pkg::*;

  // packed MSB first: code_ch0 lands in the low bits
  typedef struct packed {
    logic [CODE_W-1:0] code_ch3;
    logic [CODE_W-1:0] code_ch2;
    logic [CODE_W-1:0] code_ch1;
    logic [CODE_W-1:0] code_ch0;
  } codes_t;

  // packed MSB first: total_grams in the low bits, flags on top
  typedef struct packed {
    logic [3:0]         range_flags;
    logic [GRAMS_W-1:0] grams_ch3;
    logic [GRAMS_W-1:0] grams_ch2;
    logic [GRAMS_W-1:0] grams_ch1;
    logic [GRAMS_W-1:0] grams_ch0;
    logic [TOTAL_W-1:0] total_grams;
  } weights_t;

  // directed row: result typed in only where it is obvious
  typedef struct {
    codes_t   codes;
    bit       typed;
    weights_t weights;
  } row_t;

  localparam int HOLD_CYCLES = 4000;   // long receiver hold-off
  localparam int SETTLE      = 1500;   // more than one item's latency

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_SUPPLY;
  logic [CFG_W-1:0] cfg_data = '0;

  fsl_if #(.W($bits(codes_t)))   in_ch ();
  fsl_if #(.W($bits(weights_t))) out_ch ();

  force_sensor_linearizer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // calibration curve: ohms -> force
  longint unsigned ohm_pts [12] = '{0, 250, 300, 450, 700, 1200, 2000, 3500,
                                    6000, 10000, 30000, 100000};
  longint unsigned frc_pts [12] = '{100000, 10000, 7000, 4000, 2000, 1000,
                                    500, 250, 100, 50, 20, 12};

  // local copy of the configuration
  logic [SUPPLY_W-1:0] supply_mv = 13'd5000;
  logic [SERIES_W-1:0] series_r  = 20'd10000;

  weights_t pending_weights [$];
  int errors = 0;
  bit hold_armed = 1'b0;   // driver asks the receiver for one long hold-off

  function automatic longint unsigned force_to_grams(input longint unsigned fq8);
    return (fq8 * 100 + 490) / 981;
  endfunction

  // weight of one channel in grams Q8; sat set on a saturated channel
  function automatic longint unsigned channel_weight(input logic [CODE_W-1:0] code,
                                                     output bit sat);
    longint unsigned den, top, num, d, n;
    longint unsigned g;
    bit hit;
    sat = 1'b0;
    hit = 1'b0;
    g = force_to_grams(frc_pts[11] << 8);
    if (code == 0) begin
      sat = 1'b1;
      return g;
    end
    den = 3 * longint'(code);
    top = 32 * longint'(supply_mv);
    num = (top > den) ? longint'(series_r) * (top - den) : 0;
    for (int i = 1; i < 12; i++) begin
      if (!hit && ohm_pts[i] * den > num) begin
        hit = 1'b1;
        d = (ohm_pts[i] - ohm_pts[i-1]) * den;
        // table force falls monotonically
        n = frc_pts[i-1] * d - (frc_pts[i-1] - frc_pts[i]) * (num - ohm_pts[i-1] * den);
        g = force_to_grams((n << 8) / d);
      end
    end
    if (!hit) sat = 1'b1;
    return g;
  endfunction

  function automatic weights_t predict_weights(input codes_t c);
    weights_t w;
    longint unsigned g0, g1, g2, g3;
    bit s0, s1, s2, s3;
    g0 = channel_weight(c.code_ch0, s0);
    g1 = channel_weight(c.code_ch1, s1);
    g2 = channel_weight(c.code_ch2, s2);
    g3 = channel_weight(c.code_ch3, s3);
    w.grams_ch0   = g0[GRAMS_W-1:0];
    w.grams_ch1   = g1[GRAMS_W-1:0];
    w.grams_ch2   = g2[GRAMS_W-1:0];
    w.grams_ch3   = g3[GRAMS_W-1:0];
    w.total_grams = TOTAL_W'(g0 + g1 + g2 + g3);
    w.range_flags = {s3, s2, s1, s0};
    return w;
  endfunction

  // ---- sender -------------------------------------------------------------
  int burst_left = 0;

  // offers one item, waits for it to be taken, then maybe opens a gap
  task automatic send_codes(input codes_t c, input bit typed, input weights_t w);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= c;
    do @(posedge clk); while (!in_ch.ready);
    pending_weights.push_back(typed ? w : predict_weights(c));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 6);
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_SUPPLY) supply_mv = val[SUPPLY_W-1:0];
    else                   series_r  = val[SERIES_W-1:0];
    @(posedge clk);
  endtask

  // all results back before touching a register
  task automatic drain;
    in_ch.valid <= 1'b0;
    wait (pending_weights.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [CODE_W-1:0] pick_code;
    case ($urandom_range(0, 5))
      0:       return CODE_W'($urandom_range(0, 255));        // high resistance
      1:       return 16'(1) << $urandom_range(0, 15);
      2:       return ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
      default: return CODE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_items(input int count);
    codes_t c;
    for (int k = 0; k < count; k++) begin
      c.code_ch0 = pick_code();
      c.code_ch1 = pick_code();
      c.code_ch2 = pick_code();
      c.code_ch3 = pick_code();
      send_codes(c, 1'b0, '0);
    end
  endtask

  // ---- directed table -------------------------------------------------------
  // rows list channels from ch3 down to ch0, weights from flags down to total
  // all-zero codes: each channel 12 mN saturated -> 313 Q8 grams
  // all-max codes at reset: divider above supply -> resistance 0 -> 2609582
  row_t dir_rows [] = '{
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{4'hF, 22'd313, 22'd313, 22'd313, 22'd313, 24'd1252}},
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{4'h0, 22'd2609582, 22'd2609582, 22'd2609582, 22'd2609582, 24'd10438328}},
    '{'{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 1'b1,
      '{4'h5, 22'd2609582, 22'd313, 22'd2609582, 22'd313, 24'd5219790}},
    '{'{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b1,
      '{4'hA, 22'd313, 22'd2609582, 22'd313, 22'd2609582, 24'd5219790}},
    // code 1: resistance far past the last point
    '{'{16'h0004, 16'h0003, 16'h0002, 16'h0001}, 1'b0, '0},
    // codes just under the supply: small resistances, steep part of curve
    '{'{16'd53333, 16'd50000, 16'd52000, 16'd53000}, 1'b0, '0},
    '{'{16'd10000, 16'd20000, 16'd30000, 16'd40000}, 1'b0, '0},
    '{'{16'd800, 16'd1500, 16'd3000, 16'd5000}, 1'b0, '0},
    '{'{16'd8000, 16'd50, 16'd100, 16'd400}, 1'b0, '0},
    '{'{16'hFF00, 16'h00FF, 16'hAAAA, 16'h5555}, 1'b0, '0},
    '{'{16'd53334, 16'd44444, 16'd48484, 16'd26666}, 1'b0, '0}
  };

  // ---- receiver -------------------------------------------------------------
  initial begin
    int mode_left;
    int stall_pct;
    bit hold_done;
    out_ch.ready <= 1'b0;
    mode_left = 0;
    stall_pct = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        // long hold-off while the sender keeps offering items
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 400);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 80);
      end
      mode_left--;
      out_ch.ready <= ($urandom_range(1, 100) > stall_pct);
    end
  end

  // ---- result checker -------------------------------------------------------
  always @(posedge clk) begin
    weights_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_weights.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_weights.pop_front();
        if (got.total_grams !== want.total_grams) begin
          $display("%0t: total_grams exp %0d got %0d", $time,
                   want.total_grams, got.total_grams);
          errors++;
        end
        if (got.grams_ch0 !== want.grams_ch0) begin
          $display("%0t: grams_ch0 exp %0d got %0d", $time, want.grams_ch0, got.grams_ch0);
          errors++;
        end
        if (got.grams_ch1 !== want.grams_ch1) begin
          $display("%0t: grams_ch1 exp %0d got %0d", $time, want.grams_ch1, got.grams_ch1);
          errors++;
        end
        if (got.grams_ch2 !== want.grams_ch2) begin
          $display("%0t: grams_ch2 exp %0d got %0d", $time, want.grams_ch2, got.grams_ch2);
          errors++;
        end
        if (got.grams_ch3 !== want.grams_ch3) begin
          $display("%0t: grams_ch3 exp %0d got %0d", $time, want.grams_ch3, got.grams_ch3);
          errors++;
        end
        if (got.range_flags !== want.range_flags) begin
          $display("%0t: range_flags exp %h got %h", $time,
                   want.range_flags, got.range_flags);
          errors++;
        end
      end
    end
  end

  // ---- watchdog -------------------------------------------------------------
  // ~560 items, plus stalls, must all finish before the timeout
  initial begin
    #32000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---- main sequence --------------------------------------------------------
  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at reset settings
    foreach (dir_rows[i]) send_codes(dir_rows[i].codes, dir_rows[i].typed,
                                     dir_rows[i].weights);
    drain();

    // reset settings, with the long receiver hold-off in the middle
    random_items(30);
    hold_armed = 1'b1;
    random_items(60);
    drain();

    // small and large values of both registers
    write_reg(CFG_SUPPLY, 20'd1);
    write_reg(CFG_SERIES, 20'd1);
    random_items(40);
    drain();
    write_reg(CFG_SUPPLY, 20'd6144);
    write_reg(CFG_SERIES, 20'd1000000);
    random_items(80);
    drain();
    write_reg(CFG_SUPPLY, 20'd6144);
    write_reg(CFG_SERIES, 20'd1);
    random_items(40);
    drain();
    write_reg(CFG_SUPPLY, 20'd1);
    write_reg(CFG_SERIES, 20'd1000000);
    random_items(40);
    drain();

    // a few mid-range settings, upper register bits exercised too
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_SUPPLY, 20'($urandom_range(1, 6144)));
      write_reg(CFG_SERIES, 20'($urandom_range(1, 1000000)));
      random_items(50);
      drain();
    end

    // back to the usual 5 V / 10k divider
    write_reg(CFG_SUPPLY, 20'd5000);
    write_reg(CFG_SERIES, 20'd10000);
    random_items(60);

    in_ch.valid <= 1'b0;
    wait (pending_weights.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_weights.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- force_sensor_linearizer.f -----
sv/fsl_pkg.sv
sv/fsl_if.sv
sv/fsl_mul.sv
sv/fsl_div.sv
sv/force_sensor_linearizer.sv
tb/testbench.sv
